// ===== rtl/core/signature_scan_unique_locate_defines.svh =====
// ----------------------------------------------------------------------------
// Signature scan assertion macros
// Shared assertion shorthands for the signature scan checker.
// ----------------------------------------------------------------------------
`ifndef SIGNATURE_SCAN_UNIQUE_LOCATE_DEFINES_SVH
`define SIGNATURE_SCAN_UNIQUE_LOCATE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSUL_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: property failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSUL_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: property failed");

`endif

// ===== rtl/core/ssul_pkg.sv =====
// ----------------------------------------------------------------------------
// Signature scan package
// Types and constants shared by the signature scan front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package ssul_pkg;

  // Largest signature the register map can describe.
  localparam int unsigned MaxPatternBytes     = 16;
  localparam int unsigned PatternBytesDefault = 16;
  localparam int unsigned LenW                = 5;
  localparam int unsigned SigIdxW             = $clog2(MaxPatternBytes);
  localparam int unsigned CfgIdxW             = 3;
  localparam int unsigned CfgDataW            = 64;
  localparam int unsigned QueueDepth          = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternLow     = 3'd0,
    RegPatternHigh    = 3'd1,
    RegPatternLength  = 3'd2,
    RegRegionBase     = 3'd3,
    RegTargetDistance = 3'd4,
    RegAddDistance    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [63:0]     pattern_low;
    logic [63:0]     pattern_high;
    logic [LenW-1:0] pattern_length;
    logic [31:0]     region_base;
    logic [31:0]     target_distance;
    logic            add_distance;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] match_count;
    logic        unique_match;
    logic [31:0] found_address;
  } out_item_t;

  // One classified byte handed from the front end to the back end.
  typedef struct packed {
    logic        hit;
    logic [31:0] offset;
    logic        last;
  } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssul_front.sv =====
// ----------------------------------------------------------------------------
// Signature scan front end
// Accepts bytes, keeps the byte window and position, and flags signature hits.
// ----------------------------------------------------------------------------
`default_nettype none

module ssul_front #(
  parameter int unsigned PatternBytes = ssul_pkg::PatternBytesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssul_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssul_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output logic                push_o,
  output ssul_pkg::q_entry_t  entry_o
);
  import ssul_pkg::*;

  logic [7:0]      win_q [PatternBytes-1];
  logic [7:0]      rec   [PatternBytes];
  logic [31:0]     pos_q, pos_d;
  logic [LenW-1:0] len_eff, lenm1;
  logic [127:0]    pat;
  logic            bytes_ok;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign pat        = {cfg_i.pattern_high, cfg_i.pattern_low};

  // A length of zero behaves as one, anything above the window as the window.
  always_comb begin
    if (cfg_i.pattern_length == '0) begin
      len_eff = LenW'(1);
    end else if (cfg_i.pattern_length > LenW'(PatternBytes)) begin
      len_eff = LenW'(PatternBytes);
    end else begin
      len_eff = cfg_i.pattern_length;
    end
  end
  assign lenm1 = len_eff - LenW'(1);

  always_comb begin
    rec[0] = in_item_i.data_byte;
    for (int k = 1; k < PatternBytes; k++) begin
      rec[k] = win_q[k-1];
    end
  end

  // Byte k back from the current one must equal signature byte lenm1 - k.
  always_comb begin
    logic [SigIdxW-1:0] sig_idx;
    bytes_ok = 1'b1;
    sig_idx  = '0;
    for (int k = 0; k < PatternBytes; k++) begin
      if (LenW'(k) <= lenm1) begin
        sig_idx = SigIdxW'(lenm1 - LenW'(k));
        if (rec[k] != pat[{sig_idx, 3'b000} +: 8]) begin
          bytes_ok = 1'b0;
        end
      end
    end
  end

  always_comb begin
    entry_o.hit    = bytes_ok && (pos_q >= 32'(lenm1));
    entry_o.offset = pos_q - 32'(lenm1);
    entry_o.last   = in_item_i.last_byte;
  end

  assign pos_d = in_item_i.last_byte ? '0 : pos_q + 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
    end
  end

  // The position gate keeps stale window bytes out of every compare.
  always_ff @(posedge clk_i) begin
    if (push_o) begin
      win_q[0] <= in_item_i.data_byte;
      for (int k = 1; k < PatternBytes - 1; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssul_queue.sv =====
// ----------------------------------------------------------------------------
// Signature scan queue
// Short FIFO of classified bytes between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ssul_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ssul_pkg::q_entry_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output ssul_pkg::q_entry_t pop_data_o
);
  import ssul_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  q_entry_t        mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(QueueDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssul_back.sv =====
// ----------------------------------------------------------------------------
// Signature scan back end
// Counts hits, keeps the first match offset and resolves the final address.
// ----------------------------------------------------------------------------
`default_nettype none

module ssul_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssul_pkg::cfg_t      cfg_i,
  input  logic                ent_valid_i,
  input  ssul_pkg::q_entry_t  ent_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssul_pkg::out_item_t out_item_o
);
  import ssul_pkg::*;

  logic [31:0] adj_q;
  logic [15:0] cnt_q, cnt_nxt;
  logic [31:0] first_q, first_nxt;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;
  logic        slot_free, uniq;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = ent_valid_i && (!ent_i.last || slot_free);

  always_comb begin
    cnt_nxt   = cnt_q;
    first_nxt = first_q;
    if (ent_i.hit) begin
      if (cnt_q == '0) begin
        first_nxt = ent_i.offset;
      end
      if (cnt_q != 16'hFFFF) begin
        cnt_nxt = cnt_q + 16'd1;
      end
    end
  end

  assign uniq = (cnt_nxt == 16'd1);

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && ent_i.last) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        cnt_q <= ent_i.last ? '0 : cnt_nxt;
      end
    end
  end

  // The base plus or minus the distance only changes with configuration,
  // so it is folded into a register ahead of use and the resolve is a single add.
  always_ff @(posedge clk_i) begin
    adj_q <= cfg_i.add_distance ? cfg_i.region_base + cfg_i.target_distance
                                : cfg_i.region_base - cfg_i.target_distance;
    if (pop_o) begin
      first_q <= first_nxt;
    end
    if (pop_o && ent_i.last) begin
      out_item_q.match_count   <= cnt_nxt;
      out_item_q.unique_match  <= uniq;
      out_item_q.found_address <= uniq ? adj_q + first_nxt : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== rtl/core/signature_scan_unique_locate.sv =====
// ----------------------------------------------------------------------------
// Signature scan with unique-match locate
// Searches a byte stream for a configured signature and resolves an address.
// ----------------------------------------------------------------------------
//  Channel   Signals                              Direction  Transfer when
//  in        in_valid_i, in_ready_o, in_item_i    sink       valid && ready
//  out       out_valid_o, out_ready_i, out_item_o source     valid && ready
//  cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i     sink       cfg_we_i high
//
//  One byte is taken per cycle while the queue has room; the front end
//  compares the whole window in the cycle of the transfer and the back end
//  retires one queue entry a cycle unless stalled. A region's last byte is
//  queued and its pop sets the registered out_valid_o. Reset is asynchronous
//  and needs no clearing pass. A stalled output holds the back end only on a
//  last byte; the queue then fills and in_ready_o drops after one more byte.
// ----------------------------------------------------------------------------
`default_nettype none

module signature_scan_unique_locate #(
  parameter int unsigned PatternBytes = ssul_pkg::PatternBytesDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssul_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ssul_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ssul_pkg::in_item_t                in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ssul_pkg::out_item_t               out_item_o
);
  import ssul_pkg::*;

  cfg_t     cfg_q;
  logic     q_full, q_push, q_pop, q_valid;
  q_entry_t q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pattern_low:     '0,
                 pattern_high:    '0,
                 pattern_length:  LenW'(1),
                 region_base:     '0,
                 target_distance: '0,
                 add_distance:    1'b0};
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegPatternLow:     cfg_q.pattern_low     <= cfg_wdata_i;
        RegPatternHigh:    cfg_q.pattern_high    <= cfg_wdata_i;
        RegPatternLength:  cfg_q.pattern_length  <= cfg_wdata_i[LenW-1:0];
        RegRegionBase:     cfg_q.region_base     <= cfg_wdata_i[31:0];
        RegTargetDistance: cfg_q.target_distance <= cfg_wdata_i[31:0];
        RegAddDistance:    cfg_q.add_distance    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  ssul_front #(
    .PatternBytes(PatternBytes)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .entry_o    (q_wdata)
  );

  ssul_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  ssul_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .ent_valid_i (q_valid),
    .ent_i       (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ssul_checker.sv =====
// ----------------------------------------------------------------------------
// Signature scan checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "signature_scan_unique_locate_defines.svh"

module ssul_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  ssul_pkg::out_item_t out_item_o
);
  import ssul_pkg::*;

  // The unique flag must agree with the reported count.
  `SSUL_ASSERT_NOW(a_unique_matches_count, out_valid_o, out_item_o.unique_match == (out_item_o.match_count == 16'd1))

  // Without a unique match no address is reported.
  `SSUL_ASSERT_NOW(a_zero_addr_if_not_unique, out_valid_o && !out_item_o.unique_match, out_item_o.found_address == '0)

  // A pending result stays until its transfer.
  `SSUL_ASSERT_NEXT(a_out_valid_holds, out_valid_o && !out_ready_i, out_valid_o)

  // A pending result keeps its payload.
  `SSUL_ASSERT_NEXT(a_out_item_holds, out_valid_o && !out_ready_i, $stable(out_item_o))

endmodule

bind signature_scan_unique_locate ssul_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
